// File: hw/rtl/r2fft_pkg.sv
package r2fft_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int DATA_W = 23;
  localparam int SAMPLE_W = 16;
  localparam int TW_W = 16;
  localparam int ROM_LOG2 = 6;
  localparam int ROM_DEPTH = 32;
  localparam int CFG_DATA_W = 3;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_INVERSE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOG2 = 1'd1;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_BF_READ,
    ST_BF_WAIT,
    ST_BF_CALC,
    ST_BF_WRITE,
    ST_EMIT_READ,
    ST_EMIT_OUT
  } state_t;

  typedef logic signed [DATA_W-1:0] data_t;

  function automatic logic signed [TW_W-1:0] quarter_sine(input logic [4:0] k);
    logic signed [TW_W-1:0] v;
    case (k)
      5'd0: v = 16'sd0;
      5'd1: v = 16'sd3212;
      5'd2: v = 16'sd6393;
      5'd3: v = 16'sd9512;
      5'd4: v = 16'sd12540;
      5'd5: v = 16'sd15447;
      5'd6: v = 16'sd18205;
      5'd7: v = 16'sd20788;
      5'd8: v = 16'sd23170;
      5'd9: v = 16'sd25330;
      5'd10: v = 16'sd27246;
      5'd11: v = 16'sd28899;
      5'd12: v = 16'sd30274;
      5'd13: v = 16'sd31357;
      5'd14: v = 16'sd32138;
      5'd15: v = 16'sd32610;
      5'd16: v = 16'sd32767;
      default: v = 16'sd0;
    endcase
    return v;
  endfunction

  function automatic logic [2*TW_W-1:0] twiddle(input logic [4:0] k);
    logic signed [TW_W-1:0] c;
    logic signed [TW_W-1:0] s;
    if (k <= 5'd16) begin
      c = quarter_sine(5'd16 - k);
      s = quarter_sine(k);
    end else begin
      c = -quarter_sine(k - 5'd16);
      s = quarter_sine(5'd0 - k);
    end
    return {c, s};
  endfunction

  function automatic data_t sat23(input logic signed [DATA_W:0] x);
    data_t r;
    if (x[DATA_W] != x[DATA_W-1]) begin
      r = x[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      r = x[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/r2fft_bfly.sv
module r2fft_bfly (
  input  logic clk,
  input  logic load,
  input  logic bypass,
  input  logic inverse,
  input  logic signed [r2fft_pkg::TW_W-1:0] wr,
  input  logic signed [r2fft_pkg::TW_W-1:0] wi,
  input  r2fft_pkg::data_t ar,
  input  r2fft_pkg::data_t ai,
  input  r2fft_pkg::data_t br,
  input  r2fft_pkg::data_t bi,
  output r2fft_pkg::data_t top_r,
  output r2fft_pkg::data_t top_i,
  output r2fft_pkg::data_t bot_r,
  output r2fft_pkg::data_t bot_i
);

  localparam int PW = r2fft_pkg::DATA_W + r2fft_pkg::TW_W;

  logic signed [PW-1:0] p_rr, p_ii, p_ri, p_ir;
  logic signed [PW+1:0] sum_r, sum_i;
  logic signed [PW+1-15:0] t_r, t_i;
  logic signed [r2fft_pkg::DATA_W:0] tr, ti;
  r2fft_pkg::data_t ar_q, ai_q, br_q, bi_q;
  logic bypass_q;
  logic signed [r2fft_pkg::TW_W-1:0] wi_eff;

  assign wi_eff = inverse ? wi : -wi;

  always_ff @(posedge clk) begin
    if (load) begin
      p_rr <= PW'(wr) * PW'(br);
      p_ii <= PW'(wi_eff) * PW'(bi);
      p_ri <= PW'(wr) * PW'(bi);
      p_ir <= PW'(wi_eff) * PW'(br);
      ar_q <= ar;
      ai_q <= ai;
      br_q <= br;
      bi_q <= bi;
      bypass_q <= bypass;
    end
  end

  always_comb begin
    sum_r = (PW+2)'(p_rr) - (PW+2)'(p_ii) + (PW+2)'(16384);
    sum_i = (PW+2)'(p_ri) + (PW+2)'(p_ir) + (PW+2)'(16384);
    t_r = sum_r[PW+1:15];
    t_i = sum_i[PW+1:15];
    if (bypass_q) begin
      tr = (r2fft_pkg::DATA_W+1)'(br_q);
      ti = (r2fft_pkg::DATA_W+1)'(bi_q);
    end else begin
      tr = t_r[r2fft_pkg::DATA_W:0];
      ti = t_i[r2fft_pkg::DATA_W:0];
    end
    top_r = r2fft_pkg::sat23((r2fft_pkg::DATA_W+1)'(ar_q) + tr);
    top_i = r2fft_pkg::sat23((r2fft_pkg::DATA_W+1)'(ai_q) + ti);
    bot_r = r2fft_pkg::sat23((r2fft_pkg::DATA_W+1)'(ar_q) - tr);
    bot_i = r2fft_pkg::sat23((r2fft_pkg::DATA_W+1)'(ai_q) - ti);
  end

endmodule

// File: hw/rtl/r2fft_mem.sv
module r2fft_mem #(
  parameter int DEPTH = r2fft_pkg::MAX_POINTS_DEF,
  parameter int AW = $clog2(DEPTH)
) (
  input  logic clk,
  input  logic we_a,
  input  logic [AW-1:0] addr_a,
  input  logic [2*r2fft_pkg::DATA_W-1:0] wdata_a,
  output logic [2*r2fft_pkg::DATA_W-1:0] rdata_a,
  input  logic we_b,
  input  logic [AW-1:0] addr_b,
  input  logic [2*r2fft_pkg::DATA_W-1:0] wdata_b,
  output logic [2*r2fft_pkg::DATA_W-1:0] rdata_b
);

  logic [2*r2fft_pkg::DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we_a) begin
      mem[addr_a] <= wdata_a;
    end
    if (we_b) begin
      mem[addr_b] <= wdata_b;
    end
    rdata_a <= mem[addr_a];
    rdata_b <= mem[addr_b];
  end

endmodule

// File: hw/rtl/radix2_fft_engine_core.sv
// One word is loaded per cycle while start is high; the last word starts the FFT.
// Each butterfly steps through read, wait, calc and write states on one shared unit
// and a dual-port memory; inverse scaling is done when the bins are emitted.
// busy is high throughout the butterfly and emit states, low only while loading.
// Results are strobed after each emit read/output pair and cannot be stalled.
// Synchronous reset clears the controller, both registers and the load count only.
module radix2_fft_engine_core #(
  parameter int MAX_POINTS = r2fft_pkg::MAX_POINTS_DEF,
  parameter int AW = $clog2(MAX_POINTS)
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic signed [r2fft_pkg::SAMPLE_W-1:0] sample_real,
  input  logic signed [r2fft_pkg::SAMPLE_W-1:0] sample_imag,
  input  logic cfg_we,
  input  logic [r2fft_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [r2fft_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic bin_valid,
  output logic signed [r2fft_pkg::DATA_W-1:0] bin_real,
  output logic signed [r2fft_pkg::DATA_W-1:0] bin_imag,
  output logic [5:0] bin_index,
  output logic last_bin
);

  localparam int DW = r2fft_pkg::DATA_W;

  r2fft_pkg::state_t state, state_next;
  logic inverse_mode;
  logic [2:0] log2_points;
  logic [2:0] lg;
  logic [AW:0] load_count;
  logic [2:0] stage;
  logic [AW-1:0] bf_cnt;
  logic [AW-1:0] emit_cnt;
  logic [AW-1:0] top_addr, bot_addr, half, jj, wr_addr;
  logic [4:0] tw_idx;
  logic [AW:0] npts;
  logic last_bf, last_stage;

  logic we_a, we_b;
  logic [AW-1:0] addr_a, addr_b;
  logic [2*DW-1:0] wdata_a, wdata_b, rdata_a, rdata_b;
  r2fft_pkg::data_t top_r, top_i, bot_r, bot_i;
  logic [2*r2fft_pkg::TW_W-1:0] tw;
  logic accept;

  always_comb begin
    lg = log2_points;
    if (lg < 3'd1) begin
      lg = 3'd1;
    end
    if (32'(lg) > AW) begin
      lg = 3'(AW);
    end
  end

  assign npts = (AW+1)'(1) << lg;
  assign half = AW'((AW+1)'(1) << (stage - 3'd1));
  assign jj = bf_cnt & (half - AW'(1));
  assign top_addr = AW'(((bf_cnt & ~(half - AW'(1))) << 1) | jj);
  assign bot_addr = top_addr | half;
  assign tw_idx = 5'(32'(jj) << (r2fft_pkg::ROM_LOG2 - 32'(stage)));
  assign tw = r2fft_pkg::twiddle(tw_idx);
  assign last_bf = (AW+1)'(bf_cnt) == (npts >> 1) - (AW+1)'(1);
  assign last_stage = stage == lg;
  assign accept = start && !busy;

  always_comb begin
    wr_addr = '0;
    for (int b = 0; b < AW; b++) begin
      if (b < 32'(lg)) begin
        wr_addr[32'(lg) - 1 - b] = load_count[b];
      end
    end
  end

  r2fft_bfly u_bfly (
    .clk(clk),
    .load(state == r2fft_pkg::ST_BF_WAIT),
    .bypass(tw_idx == 5'd0),
    .inverse(inverse_mode),
    .wr(tw[31:16]),
    .wi(tw[15:0]),
    .ar(rdata_a[2*DW-1:DW]),
    .ai(rdata_a[DW-1:0]),
    .br(rdata_b[2*DW-1:DW]),
    .bi(rdata_b[DW-1:0]),
    .top_r(top_r),
    .top_i(top_i),
    .bot_r(bot_r),
    .bot_i(bot_i)
  );

  r2fft_mem #(.DEPTH(MAX_POINTS), .AW(AW)) u_mem (
    .clk(clk),
    .we_a(we_a), .addr_a(addr_a), .wdata_a(wdata_a), .rdata_a(rdata_a),
    .we_b(we_b), .addr_b(addr_b), .wdata_b(wdata_b), .rdata_b(rdata_b)
  );

  always_comb begin
    we_a = 1'b0;
    we_b = 1'b0;
    addr_a = top_addr;
    addr_b = bot_addr;
    wdata_a = {top_r, top_i};
    wdata_b = {bot_r, bot_i};
    state_next = state;
    busy = 1'b1;
    case (state)
      r2fft_pkg::ST_LOAD: begin
        busy = 1'b0;
        addr_a = wr_addr;
        wdata_a = {DW'(sample_real), DW'(sample_imag)};
        we_a = accept;
        if (accept && (load_count + (AW+1)'(1) >= npts)) begin
          state_next = r2fft_pkg::ST_BF_READ;
        end
      end
      r2fft_pkg::ST_BF_READ: state_next = r2fft_pkg::ST_BF_WAIT;
      r2fft_pkg::ST_BF_WAIT: state_next = r2fft_pkg::ST_BF_CALC;
      r2fft_pkg::ST_BF_CALC: state_next = r2fft_pkg::ST_BF_WRITE;
      r2fft_pkg::ST_BF_WRITE: begin
        we_a = 1'b1;
        we_b = 1'b1;
        state_next = (last_bf && last_stage) ? r2fft_pkg::ST_EMIT_READ
                                              : r2fft_pkg::ST_BF_READ;
      end
      r2fft_pkg::ST_EMIT_READ: begin
        addr_a = emit_cnt;
        state_next = r2fft_pkg::ST_EMIT_OUT;
      end
      r2fft_pkg::ST_EMIT_OUT: begin
        addr_a = emit_cnt;
        state_next = ((AW+1)'(emit_cnt) == npts - (AW+1)'(1)) ? r2fft_pkg::ST_LOAD
                                                               : r2fft_pkg::ST_EMIT_READ;
      end
      default: state_next = r2fft_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= r2fft_pkg::ST_LOAD;
      inverse_mode <= 1'b0;
      log2_points <= 3'd6;
      load_count <= '0;
      stage <= 3'd1;
      bf_cnt <= '0;
      emit_cnt <= '0;
      bin_valid <= 1'b0;
    end else begin
      state <= state_next;
      bin_valid <= state == r2fft_pkg::ST_EMIT_OUT;
      if (accept) begin
        load_count <= (load_count + (AW+1)'(1) >= npts) ? '0 : load_count + (AW+1)'(1);
      end
      if (state == r2fft_pkg::ST_BF_WRITE) begin
        if (last_bf) begin
          bf_cnt <= '0;
          stage <= last_stage ? 3'd1 : stage + 3'd1;
        end else begin
          bf_cnt <= bf_cnt + AW'(1);
        end
      end
      if (state == r2fft_pkg::ST_EMIT_OUT) begin
        emit_cnt <= ((AW+1)'(emit_cnt) == npts - (AW+1)'(1)) ? '0 : emit_cnt + AW'(1);
      end
      if (cfg_we && cfg_index == r2fft_pkg::REG_INVERSE) begin
        inverse_mode <= cfg_data[0];
      end
      if (cfg_we && cfg_index == r2fft_pkg::REG_LOG2) begin
        log2_points <= cfg_data;
        load_count <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == r2fft_pkg::ST_EMIT_OUT) begin
      if (inverse_mode) begin
        bin_real <= $signed(rdata_a[2*DW-1:DW]) >>> lg;
        bin_imag <= $signed(rdata_a[DW-1:0]) >>> lg;
      end else begin
        bin_real <= rdata_a[2*DW-1:DW];
        bin_imag <= rdata_a[DW-1:0];
      end
      bin_index <= 6'(emit_cnt);
      last_bin <= (AW+1)'(emit_cnt) == npts - (AW+1)'(1);
    end
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != r2fft_pkg::ST_LOAD) |-> busy)
    else $error("busy low outside load");
  a_strobe_from_emit: assert property (@(posedge clk) disable iff (rst)
    bin_valid |-> $past(state == r2fft_pkg::ST_EMIT_OUT))
    else $error("strobe without emit");
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (bin_valid && last_bin) |-> (state == r2fft_pkg::ST_LOAD))
    else $error("last bin not at frame end");
  a_load_bound: assert property (@(posedge clk) disable iff (rst)
    load_count < npts || $past(cfg_we))
    else $error("load count overrun");
`endif

endmodule

// File: verif/fft_checker.sv
`timescale 1ns / 100ps

module fft_checker (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic busy,
  input  logic signed [r2fft_pkg::SAMPLE_W-1:0] sample_real,
  input  logic signed [r2fft_pkg::SAMPLE_W-1:0] sample_imag,
  input  logic cfg_we,
  input  logic [r2fft_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [r2fft_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic bin_valid,
  input  logic signed [r2fft_pkg::DATA_W-1:0] bin_real,
  input  logic signed [r2fft_pkg::DATA_W-1:0] bin_imag,
  input  logic [5:0] bin_index,
  input  logic last_bin,
  output int pending,
  output int errors
);

  typedef struct packed {
    r2fft_pkg::data_t re;
    r2fft_pkg::data_t im;
    logic [5:0] idx;
    logic last;
  } bin_t;

  bin_t bins_due[$];
  longint mem_re[64];
  longint mem_im[64];
  longint cos_tab[32];
  longint sin_tab[32];
  logic inverse;
  logic [2:0] size_reg;
  int loaded;

  const longint quarter[17] = '{0, 3212, 6393, 9512, 12540, 15447, 18205, 20788, 23170,
                                25330, 27246, 28899, 30274, 31357, 32138, 32610, 32767};

  initial begin
    for (int k = 0; k < 32; k++) begin
      if (k <= 16) begin
        cos_tab[k] = quarter[16 - k];
        sin_tab[k] = quarter[k];
      end else begin
        cos_tab[k] = -quarter[k - 16];
        sin_tab[k] = quarter[32 - k];
      end
    end
    errors = 0;
  end

  assign pending = bins_due.size();

  function automatic longint clip_to_data(input longint x);
    if (x > 4194303) return 4194303;
    if (x < -4194304) return -4194304;
    return x;
  endfunction

  function automatic int points_log2();
    if (size_reg < 1) return 1;
    if (size_reg > 6) return 6;
    return size_reg;
  endfunction

  task automatic transform_frame(input int lg);
    int n;
    int m;
    int half;
    int top;
    int bot;
    int idx;
    longint br, bi, tr, ti, wr, wi, ar, ai;
    bin_t b;
    n = 1 << lg;
    for (int s = 1; s <= lg; s++) begin
      m = 1 << s;
      half = m >> 1;
      for (int k = 0; k < n; k += m) begin
        for (int j = 0; j < half; j++) begin
          top = k + j;
          bot = top + half;
          idx = (j << (6 - s)) & 31;
          br = mem_re[bot];
          bi = mem_im[bot];
          if (idx == 0) begin
            tr = br;
            ti = bi;
          end else begin
            wr = cos_tab[idx];
            wi = inverse ? sin_tab[idx] : -sin_tab[idx];
            tr = (wr * br - wi * bi + 16384) >>> 15;
            ti = (wr * bi + wi * br + 16384) >>> 15;
          end
          ar = mem_re[top];
          ai = mem_im[top];
          mem_re[top] = clip_to_data(ar + tr);
          mem_im[top] = clip_to_data(ai + ti);
          mem_re[bot] = clip_to_data(ar - tr);
          mem_im[bot] = clip_to_data(ai - ti);
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      if (inverse) begin
        mem_re[i] = mem_re[i] >>> lg;
        mem_im[i] = mem_im[i] >>> lg;
      end
      b.re = r2fft_pkg::data_t'(mem_re[i]);
      b.im = r2fft_pkg::data_t'(mem_im[i]);
      b.idx = 6'(i);
      b.last = (i == n - 1);
      bins_due.push_back(b);
    end
  endtask

  task automatic load_word(input longint re, input longint im);
    int lg;
    int pos;
    lg = points_log2();
    if (loaded >= (1 << lg)) loaded = 0;
    pos = 0;
    for (int b = 0; b < lg; b++) pos = (pos << 1) | ((loaded >> b) & 1);
    mem_re[pos] = re;
    mem_im[pos] = im;
    loaded++;
    if (loaded == (1 << lg)) begin
      transform_frame(lg);
      loaded = 0;
    end
  endtask

  always @(posedge clk) begin
    bin_t e;
    if (rst) begin
      inverse = 1'b0;
      size_reg = 3'd6;
      loaded = 0;
      bins_due.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == r2fft_pkg::REG_INVERSE) begin
          inverse = cfg_data[0];
        end else if (cfg_index == r2fft_pkg::REG_LOG2) begin
          size_reg = cfg_data;
          loaded = 0;
        end
      end
      if (start && !busy) load_word(sample_real, sample_imag);
      if (bin_valid) begin
        if (bins_due.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected bin %0d: %0d %0d", bin_index, bin_real,
                                     bin_imag);
        end else begin
          e = bins_due.pop_front();
          if (e.re !== bin_real || e.im !== bin_imag || e.idx !== bin_index ||
              e.last !== last_bin) begin
            errors++;
            if (errors <= 10)
              $display("bin mismatch: expected %0d %0d idx %0d last %0b, got %0d %0d idx %0d last %0b",
                       e.re, e.im, e.idx, e.last, bin_real, bin_imag, bin_index, last_bin);
          end
        end
      end
    end
  end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic signed [r2fft_pkg::SAMPLE_W-1:0] sample_real;
  logic signed [r2fft_pkg::SAMPLE_W-1:0] sample_imag;
  logic cfg_we;
  logic [r2fft_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [r2fft_pkg::CFG_DATA_W-1:0] cfg_data;
  logic bin_valid;
  logic signed [r2fft_pkg::DATA_W-1:0] bin_real;
  logic signed [r2fft_pkg::DATA_W-1:0] bin_imag;
  logic [5:0] bin_index;
  logic last_bin;
  int pending;
  int errors;
  int words_sent;
  bit quiet;

  radix2_fft_engine_core dut (.*);

  fft_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("testbench: FAIL");
    $finish;
  end

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 5))
      0: return 16'h7fff;
      1: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic write_reg(input logic [r2fft_pkg::CFG_IDX_W-1:0] idx,
                           input logic [r2fft_pkg::CFG_DATA_W-1:0] val);
    start = 1'b0;
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic send_word(input logic [15:0] re, input logic [15:0] im);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    start = 1'b1;
    sample_real = re;
    sample_imag = im;
    while (busy) @(negedge clk);
    @(negedge clk);
    words_sent++;
  endtask

  task automatic drain();
    start = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  initial begin
    int lg;
    int n;
    rst = 1'b1;
    start = 1'b0;
    sample_real = '0;
    sample_imag = '0;
    cfg_we = 1'b0;
    cfg_index = r2fft_pkg::REG_INVERSE;
    cfg_data = '0;
    words_sent = 0;
    quiet = 1'b0;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    write_reg(r2fft_pkg::REG_INVERSE, 3'd0);
    write_reg(r2fft_pkg::REG_LOG2, 3'd1);
    send_word(16'h7fff, 16'h7fff);
    send_word(16'h8000, 16'h8000);
    send_word(16'h0000, 16'hffff);
    send_word(16'hffff, 16'h0000);
    drain();
    write_reg(r2fft_pkg::REG_INVERSE, 3'd7);
    send_word(16'h8000, 16'h7fff);
    send_word(16'h7fff, 16'h8000);
    drain();
    write_reg(r2fft_pkg::REG_LOG2, 3'd0);
    send_word(16'h1234, 16'h8000);
    send_word(16'h8000, 16'h5555);
    drain();
    // A partial frame is dropped when the size register is written.
    write_reg(r2fft_pkg::REG_LOG2, 3'd2);
    send_word(16'h7fff, 16'h7fff);
    send_word(16'h7fff, 16'h7fff);
    write_reg(r2fft_pkg::REG_LOG2, 3'd2);
    // The mode is taken when the transform starts.
    send_word(16'h4000, 16'hc000);
    send_word(16'h8000, 16'h7fff);
    write_reg(r2fft_pkg::REG_INVERSE, 3'd2);
    send_word(16'h0001, 16'hfffe);
    send_word(16'h7fff, 16'h8000);
    drain();
    write_reg(r2fft_pkg::REG_LOG2, 3'd7);
    write_reg(r2fft_pkg::REG_INVERSE, 3'd1);
    for (int i = 0; i < 64; i++) send_word(i[0] ? 16'h7fff : 16'h8000, 16'h7fff);
    drain();

    while (words_sent < 400) begin
      quiet = (words_sent > 340);
      case ($urandom_range(0, 9))
        0: lg = 0;
        1: lg = 7;
        2: lg = 6;
        3: lg = 5;
        default: lg = $urandom_range(1, 4);
      endcase
      write_reg(r2fft_pkg::REG_LOG2, 3'(lg));
      write_reg(r2fft_pkg::REG_INVERSE, 3'($urandom_range(0, 7)));
      n = 1 << ((lg < 1) ? 1 : (lg > 6) ? 6 : lg);
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, n - 1 + (n == 1))) send_word(pick_sample(), pick_sample());
        write_reg(r2fft_pkg::REG_LOG2, 3'(lg));
      end
      repeat ($urandom_range(1, 3)) begin
        for (int i = 0; i < n; i++) send_word(pick_sample(), pick_sample());
      end
      drain();
    end

    drain();
    if (errors == 0 && pending == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
